// ----- sv/olir_pkg.sv -----
// Package with the shared types, widths and codes of the ordered list core.
package olir_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned IdxW   = (PosW > CntW) ? PosW : CntW;

  typedef enum logic [ReqW-1:0] {
    ReqAppend   = 3'd0,
    ReqPrepend  = 3'd1,
    ReqInsertAt = 3'd2,
    ReqSorted   = 3'd3,
    ReqPopBack  = 3'd4,
    ReqPopFront = 3'd5,
    ReqRemoveAt = 3'd6
  } req_e;

  typedef enum logic [StatW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2,
    StEmpty = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IdxW-1:0]   idx;
    logic [ValueW-1:0] value;
    logic [KeyW-1:0]   key;
  } cmd_t;

endpackage

// ----- sv/olir_if.sv -----
// Handshake interfaces for the request and result channels.
interface olir_req_if;
  logic                        valid;
  logic                        ready;
  logic [olir_pkg::ReqW-1:0]   req_type;
  logic [olir_pkg::PosW-1:0]   position;
  logic [olir_pkg::ValueW-1:0] entry_value;
  logic [olir_pkg::KeyW-1:0]   sort_key;

  modport source (output valid, req_type, position, entry_value, sort_key, input ready);
  modport sink   (input valid, req_type, position, entry_value, sort_key, output ready);
endinterface

interface olir_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [olir_pkg::StatW-1:0]  status;
  logic [olir_pkg::ValueW-1:0] removed_value;
  logic [olir_pkg::KeyW-1:0]   removed_key;
  logic [olir_pkg::PosW-1:0]   used_position;
  logic [olir_pkg::PosW-1:0]   entry_count;

  modport source (output valid, status, removed_value, removed_key, used_position,
                  entry_count, input ready);
  modport sink   (input valid, status, removed_value, removed_key, used_position,
                  entry_count, output ready);
endinterface

// ----- sv/ordered_list_insert_remove_core.sv -----
// Top level of the ordered list: request decode, count, cell chain and result register.
//
//   channel  | direction | payload
//   req_i    | in        | req_type, position, entry_value, sort_key
//   rsp_o    | out       | status, removed_value, removed_key, used_position, entry_count
//
// Each item is decoded, checked and applied to all cells in the cycle it is accepted;
// its result is registered and appears on rsp_o in the next cycle.
// One item per cycle while results are taken; the cell chain shifts in parallel, and the
// sorted position comes from a priority search over the cells' compare bits.
// Reset clears the count and the result valid; stored entries are not cleared.
// A stalled result holds; a new item is accepted in the same cycle the result is taken.
module ordered_list_insert_remove_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  olir_req_if.sink   req_i,
  olir_rsp_if.source rsp_o
);

  localparam int unsigned D = olir_pkg::Depth;

  logic [olir_pkg::IdxW-1:0]   cnt_q, cnt_d;
  logic                        acc;
  olir_pkg::req_e              req;
  olir_pkg::cmd_t              cmd;
  logic                        want_ins, want_rem;
  logic [olir_pkg::IdxW-1:0]   idx, pos_ext, sort_idx;
  olir_pkg::status_e           status;
  logic [D-1:0]                stop;
  logic [olir_pkg::ValueW-1:0] cell_value [D];
  logic [olir_pkg::KeyW-1:0]   cell_key   [D];
  logic [olir_pkg::ValueW-1:0] rd_value   [D];
  logic [olir_pkg::KeyW-1:0]   rd_key     [D];
  logic [olir_pkg::ValueW-1:0] rm_value;
  logic [olir_pkg::KeyW-1:0]   rm_key;

  logic                        valid_q;
  logic [olir_pkg::StatW-1:0]  status_q;
  logic [olir_pkg::ValueW-1:0] rm_value_q;
  logic [olir_pkg::KeyW-1:0]   rm_key_q;
  logic [olir_pkg::PosW-1:0]   used_q, used_d;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign req         = olir_pkg::req_e'(req_i.req_type);
  assign pos_ext     = olir_pkg::IdxW'(req_i.position);

  always_comb begin
    sort_idx = cnt_q;
    for (int i = D - 1; i >= 0; i--) begin
      if (stop[i]) begin
        sort_idx = olir_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    want_ins = 1'b0;
    want_rem = 1'b0;
    idx      = '0;
    case (req)
      olir_pkg::ReqAppend:   begin want_ins = 1'b1; idx = cnt_q;    end
      olir_pkg::ReqPrepend:  begin want_ins = 1'b1; idx = '0;       end
      olir_pkg::ReqInsertAt: begin want_ins = 1'b1; idx = pos_ext;  end
      olir_pkg::ReqSorted:   begin want_ins = 1'b1; idx = sort_idx; end
      olir_pkg::ReqPopBack:  begin
        want_rem = 1'b1;
        idx      = (cnt_q != '0) ? cnt_q - olir_pkg::IdxW'(1) : '0;
      end
      olir_pkg::ReqPopFront: begin want_rem = 1'b1; idx = '0;       end
      olir_pkg::ReqRemoveAt: begin want_rem = 1'b1; idx = pos_ext;  end
      default: ;
    endcase
  end

  always_comb begin
    status = olir_pkg::StOk;
    if (want_ins) begin
      if (cnt_q == olir_pkg::IdxW'(D)) begin
        status = olir_pkg::StFull;
      end else if (idx > cnt_q) begin
        status = olir_pkg::StRange;
      end
    end else if (want_rem) begin
      if (cnt_q == '0) begin
        status = olir_pkg::StEmpty;
      end else if (idx >= cnt_q) begin
        status = olir_pkg::StRange;
      end
    end
  end

  always_comb begin
    cmd.ins   = acc && want_ins && (status == olir_pkg::StOk);
    cmd.rem   = acc && want_rem && (status == olir_pkg::StOk);
    cmd.idx   = idx;
    cmd.value = req_i.entry_value;
    cmd.key   = req_i.sort_key;
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    olir_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (olir_pkg::IdxW'(g)),
      .cmd_i        (cmd),
      .cnt_i        (cnt_q),
      .srch_key_i   (req_i.sort_key),
      .prev_value_i ((g == 0) ? '0 : cell_value[(g == 0) ? 0 : g - 1]),
      .prev_key_i   ((g == 0) ? '0 : cell_key[(g == 0) ? 0 : g - 1]),
      .next_value_i ((g == D - 1) ? '0 : cell_value[(g == D - 1) ? g : g + 1]),
      .next_key_i   ((g == D - 1) ? '0 : cell_key[(g == D - 1) ? g : g + 1]),
      .value_o      (cell_value[g]),
      .key_o        (cell_key[g]),
      .stop_o       (stop[g]),
      .rd_value_o   (rd_value[g]),
      .rd_key_o     (rd_key[g])
    );
  end

  // Only the addressed cell drives nonzero read data, so an OR collects it.
  always_comb begin
    rm_value = '0;
    rm_key   = '0;
    for (int i = 0; i < D; i++) begin
      rm_value = rm_value | rd_value[i];
      rm_key   = rm_key   | rd_key[i];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + olir_pkg::IdxW'(1);
    end else if (cmd.rem) begin
      cnt_d = cnt_q - olir_pkg::IdxW'(1);
    end
    used_d = (cmd.ins || cmd.rem) ? olir_pkg::PosW'(idx) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q   <= status;
      rm_value_q <= rm_value;
      rm_key_q   <= rm_key;
      used_q     <= used_d;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = rm_value_q;
  assign rsp_o.removed_key   = rm_key_q;
  assign rsp_o.used_position = used_q;
  assign rsp_o.entry_count   = olir_pkg::PosW'(cnt_q);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= olir_pkg::IdxW'(D))
    else $error("count exceeds depth");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> cnt_q == $past(cnt_q) + olir_pkg::IdxW'(1))
    else $error("insert did not grow the count");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins && cmd.rem))
    else $error("insert and remove applied together");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == olir_pkg::StEmpty) |-> (cnt_q == '0 && rm_value_q == '0))
    else $error("empty status with entries or removed data");
`endif

endmodule

// ----- sv/olir_cell.sv -----
// One list cell: holds an entry, compares its key and shifts with its neighbors.
module olir_cell (
  input  logic                        clk_i,
  input  logic [olir_pkg::IdxW-1:0]   cell_idx_i,
  input  olir_pkg::cmd_t              cmd_i,
  input  logic [olir_pkg::IdxW-1:0]   cnt_i,
  input  logic [olir_pkg::KeyW-1:0]   srch_key_i,
  input  logic [olir_pkg::ValueW-1:0] prev_value_i,
  input  logic [olir_pkg::KeyW-1:0]   prev_key_i,
  input  logic [olir_pkg::ValueW-1:0] next_value_i,
  input  logic [olir_pkg::KeyW-1:0]   next_key_i,
  output logic [olir_pkg::ValueW-1:0] value_o,
  output logic [olir_pkg::KeyW-1:0]   key_o,
  output logic                        stop_o,
  output logic [olir_pkg::ValueW-1:0] rd_value_o,
  output logic [olir_pkg::KeyW-1:0]   rd_key_o
);

  logic [olir_pkg::ValueW-1:0] value_q, value_d;
  logic [olir_pkg::KeyW-1:0]   key_q, key_d;
  logic                        hit;

  assign hit = (cell_idx_i == cmd_i.idx);

  // A sorted insert lands at the first cell that is at or past the count or not below the key.
  assign stop_o = (cell_idx_i >= cnt_i) || !(key_q < srch_key_i);

  assign rd_value_o = (cmd_i.rem && hit) ? value_q : '0;
  assign rd_key_o   = (cmd_i.rem && hit) ? key_q   : '0;

  always_comb begin
    value_d = value_q;
    key_d   = key_q;
    if (cmd_i.ins) begin
      if (hit) begin
        value_d = cmd_i.value;
        key_d   = cmd_i.key;
      end else if (cell_idx_i > cmd_i.idx) begin
        value_d = prev_value_i;
        key_d   = prev_key_i;
      end
    end else if (cmd_i.rem && (cell_idx_i >= cmd_i.idx)) begin
      value_d = next_value_i;
      key_d   = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    key_q   <= key_d;
  end

  assign value_o = value_q;
  assign key_o   = key_q;

endmodule

// ----- test/tb.sv -----
// Testbench for the ordered list core: directed and random requests checked by a local predictor.
module tb;

  localparam logic [olir_pkg::ReqW-1:0] ReqUnused     = 3'd7;
  localparam int                        WatchdogLimit = 2000;
  localparam int                        RandomItems   = 1500;

  typedef struct {
    olir_pkg::status_e           status;
    logic [olir_pkg::ValueW-1:0] removed_value;
    logic [olir_pkg::KeyW-1:0]   removed_key;
    logic [olir_pkg::PosW-1:0]   used_position;
    logic [olir_pkg::PosW-1:0]   entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  olir_req_if req_if ();
  olir_rsp_if rsp_if ();

  ordered_list_insert_remove_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state: only entries below list_count are ever read.
  logic [olir_pkg::ValueW-1:0] list_values [olir_pkg::Depth];
  logic [olir_pkg::KeyW-1:0]   list_keys   [olir_pkg::Depth];
  int                          list_count;

  list_result_t pending_results [$];
  int           error_count;
  int           idle_cycles;
  int           rsp_hold_left;
  int           rsp_stall_left;
  bit           rsp_no_idle;
  bit           req_no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_list_request(logic [olir_pkg::ReqW-1:0] req,
                                                      logic [olir_pkg::PosW-1:0] pos,
                                                      logic [olir_pkg::ValueW-1:0] value,
                                                      logic [olir_pkg::KeyW-1:0] key);
    list_result_t res;
    int           idx;
    int           i;
    bit           ins;
    bit           rem;
    res.status        = olir_pkg::StOk;
    res.removed_value = '0;
    res.removed_key   = '0;
    res.used_position = '0;
    idx = 0;
    ins = 1'b0;
    rem = 1'b0;
    case (req)
      olir_pkg::ReqAppend:   begin ins = 1'b1; idx = list_count; end
      olir_pkg::ReqPrepend:  begin ins = 1'b1; idx = 0; end
      olir_pkg::ReqInsertAt: begin ins = 1'b1; idx = int'(pos); end
      olir_pkg::ReqSorted: begin
        ins = 1'b1;
        while (idx < list_count && list_keys[idx] < key) idx++;
      end
      olir_pkg::ReqPopBack: begin
        rem = 1'b1;
        idx = (list_count > 0) ? list_count - 1 : 0;
      end
      olir_pkg::ReqPopFront: begin rem = 1'b1; idx = 0; end
      olir_pkg::ReqRemoveAt: begin rem = 1'b1; idx = int'(pos); end
      default: ;
    endcase
    if (ins) begin
      // A full list is reported before a bad position.
      if (list_count >= olir_pkg::Depth) begin
        res.status = olir_pkg::StFull;
      end else if (idx > list_count) begin
        res.status = olir_pkg::StRange;
      end else begin
        for (i = list_count; i > idx; i--) begin
          list_values[i] = list_values[i-1];
          list_keys[i]   = list_keys[i-1];
        end
        list_values[idx] = value;
        list_keys[idx]   = key;
        list_count++;
        res.used_position = idx[olir_pkg::PosW-1:0];
      end
    end else if (rem) begin
      if (list_count == 0) begin
        res.status = olir_pkg::StEmpty;
      end else if (idx >= list_count) begin
        res.status = olir_pkg::StRange;
      end else begin
        res.removed_value = list_values[idx];
        res.removed_key   = list_keys[idx];
        list_count--;
        for (i = idx; i < list_count; i++) begin
          list_values[i] = list_values[i+1];
          list_keys[i]   = list_keys[i+1];
        end
        res.used_position = idx[olir_pkg::PosW-1:0];
      end
    end
    res.entry_count = list_count[olir_pkg::PosW-1:0];
    return res;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Narrow key ranges make ties common, so equal keys reach sorted insert.
  function automatic logic [olir_pkg::KeyW-1:0] random_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 7);
    if (r == 4) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (r == 5) return 32'h0;
    return $urandom;
  endfunction

  function automatic logic [olir_pkg::PosW-1:0] random_position(logic [olir_pkg::ReqW-1:0] req);
    bit sane;
    sane = ($urandom_range(0, 99) < 85);
    if (sane && req == olir_pkg::ReqInsertAt) begin
      return olir_pkg::PosW'($urandom_range(0, list_count));
    end
    if (sane && req == olir_pkg::ReqRemoveAt && list_count > 0) begin
      return olir_pkg::PosW'($urandom_range(0, list_count - 1));
    end
    return olir_pkg::PosW'($urandom_range(0, 31));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Called at a falling edge; valid is left high when the next item follows at once.
  task automatic send_request(input logic [olir_pkg::ReqW-1:0] req,
                              input logic [olir_pkg::PosW-1:0] pos,
                              input logic [olir_pkg::ValueW-1:0] value,
                              input logic [olir_pkg::KeyW-1:0] key);
    int gap;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= req;
    req_if.position    <= pos;
    req_if.entry_value <= value;
    req_if.sort_key    <= key;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_list_request(req, pos, value, key));
    @(negedge clk);
    gap = req_no_idle ? 0 : next_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic stop_requests();
    req_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_request(input int bias);
    logic [olir_pkg::ReqW-1:0] req;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      req = ReqUnused;
    end else if ($urandom_range(0, 99) < bias) begin
      req = olir_pkg::ReqW'($urandom_range(olir_pkg::ReqAppend, olir_pkg::ReqSorted));
    end else begin
      req = olir_pkg::ReqW'($urandom_range(olir_pkg::ReqPopBack, olir_pkg::ReqRemoveAt));
    end
    send_request(req, random_position(req), random_word(), random_key());
  endtask

  task automatic test_edge_cases();
    send_request(olir_pkg::ReqPopBack,  5'd0,  32'h1, 32'h1);
    send_request(olir_pkg::ReqPopFront, 5'd0,  32'h2, 32'h2);
    send_request(olir_pkg::ReqRemoveAt, 5'd0,  32'h3, 32'h3);
    send_request(olir_pkg::ReqRemoveAt, 5'd31, 32'h4, 32'h4);
    send_request(olir_pkg::ReqInsertAt, 5'd1,  32'h5, 32'h5);
    send_request(olir_pkg::ReqInsertAt, 5'd31, 32'h6, 32'h6);
    send_request(ReqUnused,             5'd0,  32'h7, 32'h7);
    send_request(olir_pkg::ReqInsertAt, 5'd0,  32'h0, 32'h0);
    send_request(olir_pkg::ReqAppend,   5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(olir_pkg::ReqPrepend,  5'd17, 32'h5A5A_A5A5, 32'd100);
    send_request(olir_pkg::ReqSorted,   5'd0,  32'h0000_0011, 32'd100);
    send_request(olir_pkg::ReqSorted,   5'd0,  32'h0000_0022, 32'h0);
    send_request(olir_pkg::ReqSorted,   5'd0,  32'h0000_0033, 32'hFFFF_FFFF);
    send_request(olir_pkg::ReqSorted,   5'd0,  32'h0000_0044, 32'd50);
    send_request(olir_pkg::ReqInsertAt, list_count[olir_pkg::PosW-1:0],
                 32'h1234_5678, 32'h8765_4321);
    send_request(olir_pkg::ReqRemoveAt, list_count[olir_pkg::PosW-1:0], 32'h0, 32'h0);
    send_request(olir_pkg::ReqRemoveAt, 5'd31, 32'h0, 32'h0);
    send_request(olir_pkg::ReqInsertAt, 5'd31, 32'hDEAD_BEEF, 32'h0);
    send_request(ReqUnused,             5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(olir_pkg::ReqRemoveAt, 5'd2,  32'h0, 32'h0);
    send_request(olir_pkg::ReqPopFront, 5'd0,  32'h0, 32'h0);
    send_request(olir_pkg::ReqPopBack,  5'd0,  32'h0, 32'h0);
    send_request(olir_pkg::ReqRemoveAt, 5'd0,  32'h0, 32'h0);
    stop_requests();
  endtask

  task automatic test_fill_and_drain();
    logic [olir_pkg::ReqW-1:0] req;
    while (list_count < olir_pkg::Depth) begin
      req = olir_pkg::ReqW'($urandom_range(olir_pkg::ReqAppend, olir_pkg::ReqSorted));
      send_request(req, olir_pkg::PosW'($urandom_range(0, list_count)), random_word(),
                   random_key());
    end
    send_request(olir_pkg::ReqAppend,   5'd0,  random_word(), random_key());
    send_request(olir_pkg::ReqPrepend,  5'd0,  random_word(), random_key());
    send_request(olir_pkg::ReqInsertAt, 5'd31, random_word(), random_key());
    send_request(olir_pkg::ReqInsertAt, 5'd16, random_word(), random_key());
    send_request(olir_pkg::ReqSorted,   5'd0,  random_word(), random_key());
    send_request(olir_pkg::ReqRemoveAt, 5'd16, 32'h0, 32'h0);
    while (list_count > 0) begin
      req = olir_pkg::ReqW'($urandom_range(olir_pkg::ReqPopBack, olir_pkg::ReqRemoveAt));
      send_request(req, olir_pkg::PosW'($urandom_range(0, list_count - 1)), random_word(),
                   random_key());
    end
    send_request(olir_pkg::ReqPopFront, 5'd0, 32'h0, 32'h0);
    stop_requests();
  endtask

  // The result side holds off for a long stretch while items keep coming.
  task automatic test_result_backpressure();
    int i;
    req_no_idle   = 1'b1;
    rsp_hold_left = 300;
    for (i = 0; i < 40; i++) send_random_request(60);
    req_no_idle = 1'b0;
    stop_requests();
  endtask

  task automatic test_random_mix();
    int i;
    int bias;
    bias = 50;
    for (i = 0; i < RandomItems; i++) begin
      // Phases that grow, shrink or hold the list, with and without idling.
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 75;
          1:       bias = 25;
          default: bias = 50;
        endcase
        req_no_idle = ($urandom_range(0, 3) == 0);
        rsp_no_idle = ($urandom_range(0, 3) == 0);
      end
      send_random_request(bias);
    end
    req_no_idle = 1'b0;
    rsp_no_idle = 1'b0;
    stop_requests();
  endtask

  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold_left--;
    end else if (rsp_stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall_left = rsp_no_idle ? 0 : next_gap();
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d count %0d", $time,
                 rsp_if.status, rsp_if.entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",        want.status,        rsp_if.status);
        check_field("removed_value", want.removed_value, rsp_if.removed_value);
        check_field("removed_key",   want.removed_key,   rsp_if.removed_key);
        check_field("used_position", want.used_position, rsp_if.used_position);
        check_field("entry_count",   want.entry_count,   rsp_if.entry_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = '0;
    req_if.position    = '0;
    req_if.entry_value = '0;
    req_if.sort_key    = '0;
    rsp_if.ready       = 1'b0;
    list_count         = 0;
    error_count        = 0;
    idle_cycles        = 0;
    rsp_hold_left      = 0;
    rsp_stall_left     = 0;
    rsp_no_idle        = 1'b0;
    req_no_idle        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edge_cases();
    test_fill_and_drain();
    test_result_backpressure();
    test_random_mix();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
